// ===== src/cfrc_pkg.sv =====
// Shared types and constants of the chunked frame reassembly checker.
// Used by every module under src; depends on nothing else.

package cfrc_pkg;

    // Fixed size of the chunk header and widths of the counters and item fields
    localparam int HEADER_BYTES = 24;
    localparam int CNT_W        = 25;
    localparam int DGRAM_W      = 17;
    localparam int LEN_W        = 16;
    localparam int VER_W        = 16;
    localparam int POS_W        = 32;
    localparam int STATUS_W     = 3;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd0;
    localparam logic [1:0] REG_MAX_CHUNK_BYTES  = 2'd1;
    localparam logic [1:0] REG_MAX_FRAME_BYTES  = 2'd2;

    // Register reset values
    localparam logic [VER_W-1:0] RST_PROTOCOL_VERSION = 16'd1;
    localparam logic [LEN_W-1:0] RST_MAX_CHUNK_BYTES  = 16'd16384;
    localparam logic [CNT_W-1:0] RST_MAX_FRAME_BYTES  = 25'h100_0000;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MORE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORM  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_START = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TOT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd7;

    // Input operation codes
    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [VER_W-1:0] protocol_version;
        logic [LEN_W-1:0] max_chunk_bytes;
        logic [CNT_W-1:0] max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic [VER_W-1:0]   version;
        logic [DGRAM_W-1:0] datagram_bytes;
        logic [LEN_W-1:0]   chunk_length;
        logic [POS_W-1:0]   frame_total;
        logic [POS_W-1:0]   chunk_offset;
        logic               more_flag;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    write_offset;
        logic [CNT_W-1:0]    bytes_received;
        logic                frame_active;
    } result_t;

endpackage

// ===== src/cfrc_cfg.sv =====
// APB configuration registers of the reassembly checker.
// Depends on cfrc_pkg for the register map and reset values.

module cfrc_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cfrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cfrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output cfrc_pkg::cfg_t                  cfg
);

    logic [cfrc_pkg::VER_W-1:0] version_reg;
    logic [cfrc_pkg::LEN_W-1:0] max_chunk_reg;
    logic [cfrc_pkg::CNT_W-1:0] max_frame_reg;
    logic [1:0]                 index;
    logic                       wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // Write the addressed register in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= cfrc_pkg::RST_PROTOCOL_VERSION;
            max_chunk_reg <= cfrc_pkg::RST_MAX_CHUNK_BYTES;
            max_frame_reg <= cfrc_pkg::RST_MAX_FRAME_BYTES;
        end
        else if (wr_en)
        begin
            unique case (index)
                cfrc_pkg::REG_PROTOCOL_VERSION:
                    version_reg <= pwdata[cfrc_pkg::VER_W-1:0];
                cfrc_pkg::REG_MAX_CHUNK_BYTES:
                    max_chunk_reg <= pwdata[cfrc_pkg::LEN_W-1:0];
                cfrc_pkg::REG_MAX_FRAME_BYTES:
                    max_frame_reg <= pwdata[cfrc_pkg::CNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (index)
            cfrc_pkg::REG_PROTOCOL_VERSION: prdata = 32'(version_reg);
            cfrc_pkg::REG_MAX_CHUNK_BYTES:  prdata = 32'(max_chunk_reg);
            cfrc_pkg::REG_MAX_FRAME_BYTES:  prdata = 32'(max_frame_reg);
            default:                        prdata = '0;
        endcase
    end

    assign cfg.protocol_version = version_reg;
    assign cfg.max_chunk_bytes  = max_chunk_reg;
    assign cfg.max_frame_bytes  = max_frame_reg;

endmodule

// ===== src/cfrc_eval.sv =====
// Chunk checker: frame state registers and the combinational decision logic.
// Depends on cfrc_pkg for item, result and configuration types.

module cfrc_eval
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfrc_pkg::cfg_t    cfg,
    input  cfrc_pkg::item_t   item,
    input  logic              advance,
    output cfrc_pkg::result_t result
);

    logic                          open_reg;
    logic                          open_next;
    logic [cfrc_pkg::CNT_W-1:0]    count_reg;
    logic [cfrc_pkg::CNT_W-1:0]    count_next;
    logic [cfrc_pkg::CNT_W-1:0]    cap_reg;
    logic [cfrc_pkg::CNT_W-1:0]    cap_next;

    logic [cfrc_pkg::DGRAM_W-1:0]  dgram_expect;
    logic                          malformed;
    logic [cfrc_pkg::CNT_W-1:0]    count_eff;
    logic [cfrc_pkg::CNT_W-1:0]    cap_eff;
    logic [cfrc_pkg::CNT_W:0]      sum;
    logic [cfrc_pkg::STATUS_W-1:0] status;
    logic [cfrc_pkg::CNT_W-1:0]    woff;

    // Form check of the datagram
    assign dgram_expect = cfrc_pkg::DGRAM_W'(cfrc_pkg::HEADER_BYTES)
                        + cfrc_pkg::DGRAM_W'(item.chunk_length);
    assign malformed = (item.datagram_bytes < cfrc_pkg::DGRAM_W'(cfrc_pkg::HEADER_BYTES))
                    || (item.version != cfg.protocol_version)
                    || (item.chunk_length > cfg.max_chunk_bytes)
                    || (item.datagram_bytes != dgram_expect);

    // A chunk taken while idle sees a freshly opened frame
    assign count_eff = open_reg ? count_reg : '0;
    assign cap_eff   = open_reg ? cap_reg : item.frame_total[cfrc_pkg::CNT_W-1:0];
    assign sum       = {1'b0, count_eff} + (cfrc_pkg::CNT_W+1)'(item.chunk_length);

    // Decide the status and the next frame state
    always_comb
    begin
        open_next  = open_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        status     = cfrc_pkg::ST_MALFORM;
        woff       = '0;
        priority if (item.op == cfrc_pkg::OP_RELEASE)
        begin
            open_next  = 1'b0;
            count_next = '0;
            cap_next   = '0;
            status     = cfrc_pkg::ST_RELEASED;
        end
        else if (malformed)
        begin
            status = cfrc_pkg::ST_MALFORM;
        end
        else if (!open_reg && (item.chunk_offset != '0))
        begin
            status = cfrc_pkg::ST_NO_START;
        end
        else if (!open_reg && ((item.frame_total == '0)
                 || (item.frame_total > cfrc_pkg::POS_W'(cfg.max_frame_bytes))))
        begin
            status = cfrc_pkg::ST_BAD_TOT;
        end
        else if ((item.chunk_offset != cfrc_pkg::POS_W'(count_eff))
                 || (sum > {1'b0, cap_eff}))
        begin
            open_next  = 1'b0;
            count_next = '0;
            cap_next   = '0;
            status     = cfrc_pkg::ST_ORDER;
        end
        else if (!item.more_flag && (sum[cfrc_pkg::CNT_W-1:0] != cap_eff))
        begin
            open_next  = 1'b0;
            count_next = '0;
            cap_next   = '0;
            status     = cfrc_pkg::ST_SHORT;
        end
        else
        begin
            open_next  = 1'b1;
            count_next = sum[cfrc_pkg::CNT_W-1:0];
            cap_next   = cap_eff;
            status     = item.more_flag ? cfrc_pkg::ST_MORE : cfrc_pkg::ST_COMPLETE;
            woff       = count_eff;
        end
    end

    // Hold the frame state; advance it with each item leaving the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            cap_reg   <= '0;
        end
        else if (advance)
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    assign result.status         = status;
    assign result.write_offset   = woff;
    assign result.bytes_received = count_next;
    assign result.frame_active   = open_next;

`ifndef NO_ASSERTIONS
    // The count never runs past the frame capacity
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("received count exceeds frame capacity");

    // An idle checker carries no count and no capacity
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (count_reg == '0) && (cap_reg == '0))
        else $error("idle state holds stale counters");

    // A malformed datagram leaves the frame untouched
    a_malform_keep: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (status == cfrc_pkg::ST_MALFORM)
        |=> (open_reg == $past(open_reg)) && (count_reg == $past(count_reg))
            && (cap_reg == $past(cap_reg)))
        else $error("malformed datagram changed frame state");
`endif

endmodule

// ===== src/chunked_frame_reassembly_checker.sv =====
// Top level of the chunked frame reassembly checker: input stage, result stage
// and wiring of cfrc_cfg and cfrc_eval; depends on cfrc_pkg.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    op version datagram_bytes chunk_length
//                                   frame_total chunk_offset more_flag
//   result   out_valid / out_ready  status write_offset bytes_received frame_active
//   config   APB psel/penable       paddr pwdata prdata (pready tied high)
//
// One item per cycle while the result is not stalled: an item is held in the input
// register, is checked against the frame state in one pass and lands in the result
// register, from which out_valid offers it until it is taken.
// The frame state updates as the item moves to the result register, so the next
// item sees it at once.
// Reset clears the frame state and loads the register defaults.
// A stalled result holds both stages; each stage refills as it empties.

module chunked_frame_reassembly_checker
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [cfrc_pkg::VER_W-1:0]        version,
    input  logic [cfrc_pkg::DGRAM_W-1:0]      datagram_bytes,
    input  logic [cfrc_pkg::LEN_W-1:0]        chunk_length,
    input  logic [cfrc_pkg::POS_W-1:0]        frame_total,
    input  logic [cfrc_pkg::POS_W-1:0]        chunk_offset,
    input  logic                              more_flag,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cfrc_pkg::STATUS_W-1:0]     status,
    output logic [cfrc_pkg::CNT_W-1:0]        write_offset,
    output logic [cfrc_pkg::CNT_W-1:0]        bytes_received,
    output logic                              frame_active,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cfrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cfrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    cfrc_pkg::cfg_t    cfg;
    cfrc_pkg::item_t   item_reg;
    cfrc_pkg::result_t result;
    cfrc_pkg::result_t result_reg;
    logic              item_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    // Move forward whenever the result register is free or being emptied
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    cfrc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfrc_eval u_eval
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op             <= op;
            item_reg.version        <= version;
            item_reg.datagram_bytes <= datagram_bytes;
            item_reg.chunk_length   <= chunk_length;
            item_reg.frame_total    <= frame_total;
            item_reg.chunk_offset   <= chunk_offset;
            item_reg.more_flag      <= more_flag;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign write_offset   = result_reg.write_offset;
    assign bytes_received = result_reg.bytes_received;
    assign frame_active   = result_reg.frame_active;

endmodule
